>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the triangle indexer RTL.
// Both macros check on the rising clock edge and stay quiet while in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SMTI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define SMTI_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define SMTI_ASSERT(lbl, clk, rstn, prop, msg)
`define SMTI_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> hdl/smti_pkg.sv
// ---------------------------------------------------------------------------
// smti_pkg
// Types, constants and helpers shared by the sphere mesh triangle indexer.
// ---------------------------------------------------------------------------
package smti_pkg;

  localparam int DEF_MAX_SEGMENTS = 256;
  localparam int DEF_MAX_RINGS    = 256;

  localparam int CFG_W   = 9;
  localparam int IDX_W   = 16;
  localparam int PROD_W  = 2 * CFG_W - 1;
  localparam int NSTG    = IDX_W / 2;
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  localparam logic [CFG_W-1:0] CFG_MIN      = CFG_W'(3);
  localparam logic [CFG_W-1:0] RST_SEGMENTS = CFG_W'(8);
  localparam logic [CFG_W-1:0] RST_RINGS    = CFG_W'(8);

  localparam logic REG_RING_SEGMENTS = 1'b0;
  localparam logic REG_RING_COUNT    = 1'b1;

  // One classified word handed from the front end to the emitter.
  typedef struct packed {
    logic             err;
    logic             first_ring;
    logic             last_ring;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] nbr;
    logic [CFG_W-1:0] seg;
    logic [IDX_W-1:0] pole;
  } tri_entry_t;

  // One restoring-division step: shift in a dividend bit, subtract if it fits.
  function automatic logic [CFG_W-1:0] rem_step(logic [CFG_W-1:0] rem, logic bit_in,
                                                logic [CFG_W-1:0] div);
    logic [CFG_W:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, div}) begin
      t = t - {1'b0, div};
    end
    return t[CFG_W-1:0];
  endfunction

endpackage

>>> hdl/sphere_mesh_triangle_indexer.sv
// ---------------------------------------------------------------------------
// sphere_mesh_triangle_indexer
// Turns a UV-sphere vertex index into the triangles built for that vertex.
//
//   channel  ports                                     handshake
//   input    in_vertex_index                           start & !busy
//   result   out_corner_a/b/c, out_last_triangle,      out_strobe, one cycle,
//            out_index_error                           no back pressure
//   config   cfg_index, cfg_wdata                      cfg_we, single cycle
//
// A word is taken in any cycle that busy is low. The result port carries one
// triangle per cycle while a word waits in the queue; a word gives one for a
// bad index or a last-ring vertex, two for a middle ring, three for the first
// ring. Each word holds a credit from when it is taken until its last
// triangle, so a run of one-triangle words can be held back by the credits.
// The first result passes the input register, the eight-stage remainder
// pipeline, the queue and the output register. Busy rises while eight words
// are taken and not yet finished. Reset is synchronous and sets both
// settings to eight; there is no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sphere_mesh_triangle_indexer #(
  parameter int MAX_SEGMENTS = smti_pkg::DEF_MAX_SEGMENTS,
  parameter int MAX_RINGS    = smti_pkg::DEF_MAX_RINGS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [smti_pkg::IDX_W-1:0] in_vertex_index,
  output logic                       out_strobe,
  output logic [smti_pkg::IDX_W-1:0] out_corner_a,
  output logic [smti_pkg::IDX_W-1:0] out_corner_b,
  output logic [smti_pkg::IDX_W-1:0] out_corner_c,
  output logic                       out_last_triangle,
  output logic                       out_index_error,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [smti_pkg::CFG_W-1:0] cfg_wdata
);
  import smti_pkg::*;

  logic [CFG_W-1:0]  seg_cfg_r;
  logic [CFG_W-1:0]  ring_cfg_r;
  logic [QCNT_W-1:0] occ_r;
  logic [QCNT_W-1:0] occ_nxt;
  logic              take;
  logic              ent_valid;
  tri_entry_t        ent;
  logic              head_valid;
  tri_entry_t        head;
  logic              pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_cfg_r  <= RST_SEGMENTS;
      ring_cfg_r <= RST_RINGS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RING_SEGMENTS: seg_cfg_r  <= cfg_wdata;
        REG_RING_COUNT:    ring_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Credits cover words in the pipeline as well as those queued, so the
  // queue can never overflow.
  assign busy = (occ_r == QCNT_W'(QDEPTH));
  assign take = start && !busy;

  always_comb begin
    occ_nxt = occ_r;
    if (take && !pop) begin
      occ_nxt = occ_r + QCNT_W'(1);
    end else if (pop && !take) begin
      occ_nxt = occ_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  smti_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .MAX_RINGS   (MAX_RINGS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (take),
    .in_idx   (in_vertex_index),
    .seg_cfg  (seg_cfg_r),
    .ring_cfg (ring_cfg_r),
    .ent_valid(ent_valid),
    .ent      (ent)
  );

  smti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ent_valid),
    .push_data (ent),
    .pop       (pop),
    .head_valid(head_valid),
    .head_data (head)
  );

  smti_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_strobe       (out_strobe),
    .out_corner_a     (out_corner_a),
    .out_corner_b     (out_corner_b),
    .out_corner_c     (out_corner_c),
    .out_last_triangle(out_last_triangle),
    .out_index_error  (out_index_error)
  );

  `SMTI_ASSERT(a_occ_bound, clk, rst_n, occ_r <= QCNT_W'(QDEPTH), "credit count overrun")
  `SMTI_NEVER(a_pop_credit, clk, rst_n, pop && (occ_r == '0), "word retired without credit")

endmodule

>>> hdl/smti_front.sv
// ---------------------------------------------------------------------------
// smti_front
// Takes vertex indices, classifies them against the mesh size and finds the
// ring wrap with a pipelined remainder unit, two dividend bits per stage.
// ---------------------------------------------------------------------------
module smti_front #(
  parameter int MAX_SEGMENTS = smti_pkg::DEF_MAX_SEGMENTS,
  parameter int MAX_RINGS    = smti_pkg::DEF_MAX_RINGS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_take,
  input  logic [smti_pkg::IDX_W-1:0] in_idx,
  input  logic [smti_pkg::CFG_W-1:0] seg_cfg,
  input  logic [smti_pkg::CFG_W-1:0] ring_cfg,
  output logic                       ent_valid,
  output smti_pkg::tri_entry_t       ent
);
  import smti_pkg::*;

  localparam logic [CFG_W-1:0] SEG_HI  = CFG_W'(MAX_SEGMENTS);
  localparam logic [CFG_W-1:0] RING_HI = CFG_W'(MAX_RINGS);

  logic [CFG_W-1:0]  seg_c;
  logic [CFG_W-1:0]  ring_c;
  logic [CFG_W-1:0]  ring_m1;
  logic [PROD_W-1:0] prod_nxt;
  logic [PROD_W-1:0] prod_r;

  logic [NSTG:0]     v_r;
  logic [IDX_W-1:0]  idx_r  [NSTG+1];
  logic [CFG_W-1:0]  seg_r  [NSTG+1];
  logic [CFG_W-1:0]  rem_r  [1:NSTG];
  logic [CFG_W-1:0]  rem_in [1:NSTG];
  logic [CFG_W-1:0]  rem_nxt[1:NSTG];
  logic [NSTG:1]     err_r;
  logic [NSTG:1]     fst_r;
  logic [NSTG:1]     lst_r;
  logic [IDX_W-1:0]  pole_r [1:NSTG];

  logic              err_nxt;
  logic              fst_nxt;
  logic              lst_nxt;
  logic [IDX_W-1:0]  pole_nxt;
  logic [CFG_W-1:0]  rem_mid;
  logic              wrap;

  // Out-of-range settings are pinned to the supported range.
  always_comb begin
    if (seg_cfg < CFG_MIN) begin
      seg_c = CFG_MIN;
    end else if (seg_cfg > SEG_HI) begin
      seg_c = SEG_HI;
    end else begin
      seg_c = seg_cfg;
    end
    if (ring_cfg < CFG_MIN) begin
      ring_c = CFG_MIN;
    end else if (ring_cfg > RING_HI) begin
      ring_c = RING_HI;
    end else begin
      ring_c = ring_cfg;
    end
    ring_m1  = ring_c - CFG_W'(1);
    prod_nxt = PROD_W'(ring_m1) * PROD_W'(seg_c);
  end

  // prod_r is N-2, the highest legal index.
  always_comb begin
    err_nxt  = (idx_r[0] == '0) || (PROD_W'(idx_r[0]) > prod_r);
    fst_nxt  = PROD_W'(idx_r[0]) <= PROD_W'(seg_r[0]);
    lst_nxt  = PROD_W'(idx_r[0]) > (prod_r - PROD_W'(seg_r[0]));
    pole_nxt = prod_r[IDX_W-1:0] + IDX_W'(1);
  end

  always_comb begin
    rem_mid   = '0;
    rem_in[1] = '0;
    for (int k = 2; k <= NSTG; k++) begin
      rem_in[k] = rem_r[k-1];
    end
    for (int k = 1; k <= NSTG; k++) begin
      rem_mid    = rem_step(rem_in[k], idx_r[k-1][IDX_W-2*k+1], seg_r[k-1]);
      rem_nxt[k] = rem_step(rem_mid, idx_r[k-1][IDX_W-2*k], seg_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NSTG-1:0], in_take};
    end
  end

  always_ff @(posedge clk) begin
    idx_r[0]  <= in_idx;
    seg_r[0]  <= seg_c;
    prod_r    <= prod_nxt;
    err_r[1]  <= err_nxt;
    fst_r[1]  <= fst_nxt;
    lst_r[1]  <= lst_nxt;
    pole_r[1] <= pole_nxt;
    for (int k = 1; k <= NSTG; k++) begin
      idx_r[k] <= idx_r[k-1];
      seg_r[k] <= seg_r[k-1];
      rem_r[k] <= rem_nxt[k];
    end
    for (int k = 2; k <= NSTG; k++) begin
      err_r[k]  <= err_r[k-1];
      fst_r[k]  <= fst_r[k-1];
      lst_r[k]  <= lst_r[k-1];
      pole_r[k] <= pole_r[k-1];
    end
  end

  // A multiple of the segment count wraps back to the start of its ring.
  assign wrap = (rem_r[NSTG] == '0);

  always_comb begin
    ent.err        = err_r[NSTG];
    ent.first_ring = fst_r[NSTG];
    ent.last_ring  = lst_r[NSTG];
    ent.idx        = idx_r[NSTG];
    ent.seg        = seg_r[NSTG];
    ent.pole       = pole_r[NSTG];
    if (wrap) begin
      ent.nbr = idx_r[NSTG] + IDX_W'(1) - IDX_W'(seg_r[NSTG]);
    end else begin
      ent.nbr = idx_r[NSTG] + IDX_W'(1);
    end
  end

  assign ent_valid = v_r[NSTG];

endmodule

>>> hdl/smti_queue.sv
// ---------------------------------------------------------------------------
// smti_queue
// Short register queue between the classifying front end and the emitter.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module smti_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  smti_pkg::tri_entry_t push_data,
  input  logic                 pop,
  output logic                 head_valid,
  output smti_pkg::tri_entry_t head_data
);
  import smti_pkg::*;

  tri_entry_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  `SMTI_NEVER(a_q_overflow, clk, rst_n, push && (cnt_r == QCNT_W'(QDEPTH)), "queue overflow")
  `SMTI_NEVER(a_q_underflow, clk, rst_n, pop && (cnt_r == '0), "queue underflow")

endmodule

>>> hdl/smti_back.sv
// ---------------------------------------------------------------------------
// smti_back
// Emits the triangles of the word at the head of the queue, one per cycle,
// and retires the word with its last triangle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module smti_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  smti_pkg::tri_entry_t       head,
  output logic                       pop,
  output logic                       out_strobe,
  output logic [smti_pkg::IDX_W-1:0] out_corner_a,
  output logic [smti_pkg::IDX_W-1:0] out_corner_b,
  output logic [smti_pkg::IDX_W-1:0] out_corner_c,
  output logic                       out_last_triangle,
  output logic                       out_index_error
);
  import smti_pkg::*;

  typedef enum logic [2:0] {
    PH_OPEN   = 3'b001,
    PH_BAND_A = 3'b010,
    PH_BAND_B = 3'b100
  } phase_t;

  phase_t           ph_r;
  phase_t           ph_nxt;
  logic [IDX_W-1:0] i_plus_s;
  logic [IDX_W-1:0] p_plus_s;

  logic             strobe_r;
  logic [IDX_W-1:0] corner_a_r, corner_a_nxt;
  logic [IDX_W-1:0] corner_b_r, corner_b_nxt;
  logic [IDX_W-1:0] corner_c_r, corner_c_nxt;
  logic             last_r, last_nxt;
  logic             err_r, err_nxt;

  assign i_plus_s = head.idx + IDX_W'(head.seg);
  assign p_plus_s = head.nbr + IDX_W'(head.seg);

  always_comb begin
    ph_nxt       = ph_r;
    pop          = 1'b0;
    corner_a_nxt = '0;
    corner_b_nxt = '0;
    corner_c_nxt = '0;
    last_nxt     = 1'b0;
    err_nxt      = 1'b0;
    if (head_valid) begin
      unique case (ph_r)
        PH_OPEN: begin
          priority if (head.err) begin
            last_nxt = 1'b1;
            err_nxt  = 1'b1;
            pop      = 1'b1;
          end else if (head.first_ring) begin
            // Top cap against the north pole, vertex zero.
            corner_b_nxt = head.idx;
            corner_c_nxt = head.nbr;
            ph_nxt       = PH_BAND_A;
          end else if (head.last_ring) begin
            corner_a_nxt = head.pole;
            corner_b_nxt = head.nbr;
            corner_c_nxt = head.idx;
            last_nxt     = 1'b1;
            pop          = 1'b1;
          end else begin
            corner_a_nxt = i_plus_s;
            corner_b_nxt = head.nbr;
            corner_c_nxt = head.idx;
            ph_nxt       = PH_BAND_B;
          end
        end
        PH_BAND_A: begin
          corner_a_nxt = i_plus_s;
          corner_b_nxt = head.nbr;
          corner_c_nxt = head.idx;
          ph_nxt       = PH_BAND_B;
        end
        PH_BAND_B: begin
          corner_a_nxt = i_plus_s;
          corner_b_nxt = p_plus_s;
          corner_c_nxt = head.nbr;
          last_nxt     = 1'b1;
          pop          = 1'b1;
          ph_nxt       = PH_OPEN;
        end
        default: begin
          ph_nxt = PH_OPEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= PH_OPEN;
      strobe_r <= 1'b0;
    end else begin
      ph_r     <= ph_nxt;
      strobe_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    corner_a_r <= corner_a_nxt;
    corner_b_r <= corner_b_nxt;
    corner_c_r <= corner_c_nxt;
    last_r     <= last_nxt;
    err_r      <= err_nxt;
  end

  assign out_strobe        = strobe_r;
  assign out_corner_a      = corner_a_r;
  assign out_corner_b      = corner_b_r;
  assign out_corner_c      = corner_c_r;
  assign out_last_triangle = last_r;
  assign out_index_error   = err_r;

  // A word part way through its triangles must still sit at the queue head.
  `SMTI_ASSERT(a_mid_word_held, clk, rst_n, (ph_r == PH_OPEN) || head_valid, "word left mid-emit")
  `SMTI_ASSERT(a_err_word_zero, clk, rst_n, !(strobe_r && err_r) || (last_r && (corner_a_r == '0) && (corner_b_r == '0) && (corner_c_r == '0)), "bad error word")

endmodule
